// File: hdl/dmrn_pkg.sv
// Shared types and constants of the int8 dual MAC requantizing neuron.
package dmrn_pkg;

    localparam int MULT_W    = 31;
    localparam int FS_W      = 6;
    localparam int BIAS_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MULT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_EN    = 2'd3;

    localparam logic [MULT_W-1:0] MULT_RESET = 31'd65536;
    localparam logic [FS_W-1:0]   FS_RESET   = 6'd16;

    localparam logic [7:0] INT8_MAX = 8'h7F;
    localparam logic [7:0] INT8_MIN = 8'h80;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_BIAS,
        B_ABS,
        B_ROUND,
        B_SAT
    } back_state_t;

endpackage

// File: hdl/dmrn_front.sv
// Front end: takes weight/activation pairs and accumulates the dot product.
module dmrn_front #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [7:0]       weight_lo,
    input  logic signed [7:0]       act_lo,
    input  logic signed [7:0]       weight_hi,
    input  logic signed [7:0]       act_hi,
    input  logic                    last_pair,
    input  dmrn_pkg::q_stat_t       q_stat,
    output logic                    q_push,
    output logic [ACC_WIDTH-1:0]    q_wdata
);
    import dmrn_pkg::*;

    logic signed [15:0]     prod_lo;
    logic signed [15:0]     prod_hi;
    logic signed [16:0]     pair_sum;
    logic [ACC_WIDTH-1:0]   acc_reg;
    logic [ACC_WIDTH-1:0]   acc_next;
    logic                   xfer;

    assign in_ready = !q_stat.full;
    assign xfer     = in_valid && in_ready;

    assign prod_lo  = weight_lo * act_lo;
    assign prod_hi  = weight_hi * act_hi;
    assign pair_sum = 17'(prod_lo) + 17'(prod_hi);
    assign acc_next = acc_reg + ACC_WIDTH'(pair_sum);

    // Hand the finished sum to the queue on the last pair.
    assign q_push  = xfer && last_pair;
    assign q_wdata = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (xfer)
        begin
            acc_reg <= last_pair ? '0 : acc_next;
        end
    end

endmodule

// File: hdl/dmrn_queue.sv
// Two-entry queue of finished accumulator sums between front and back end.
module dmrn_queue #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [ACC_WIDTH-1:0]    wdata,
    input  logic                    pop,
    output logic [ACC_WIDTH-1:0]    rdata,
    output dmrn_pkg::q_stat_t       stat
);
    import dmrn_pkg::*;

    logic [ACC_WIDTH-1:0]   mem_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QPTR_W:0]        count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/dmrn_back.sv
// Back end: requantizes one accumulator sum to int8 over a short sequence.
module dmrn_back #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dmrn_pkg::MULT_W-1:0] mult,
    input  logic [dmrn_pkg::FS_W-1:0]   frac_shift,
    input  logic [dmrn_pkg::BIAS_W-1:0] bias,
    input  logic                        relu_en,
    input  logic [ACC_WIDTH-1:0]        q_rdata,
    input  dmrn_pkg::q_stat_t           q_stat,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [7:0]           out_act,
    output logic                        clipped
);
    import dmrn_pkg::*;

    localparam int LOW = ACC_WIDTH / 2;
    localparam int HIW = ACC_WIDTH - LOW;
    localparam int PW  = ACC_WIDTH + MULT_W;
    localparam int VW  = (PW + 2 > 65) ? PW + 2 : 65;

    back_state_t            state_reg;
    back_state_t            state_next;

    logic [ACC_WIDTH-1:0]   mag_reg;
    logic                   aneg_reg;
    logic [LOW+MULT_W-1:0]  plo_reg;
    logic [HIW+MULT_W-1:0]  phi_reg;
    logic [VW-1:0]          v_reg;
    logic                   vneg_reg;
    logic [VW-1:0]          half;
    logic [VW-1:0]          rounded;
    logic [VW-1:0]          bias_ext;
    logic                   upper_nz;
    logic                   sat_clip;
    logic [7:0]             sat_act;
    logic                   out_free;
    logic                   load_out;
    logic                   out_valid_reg;
    logic [7:0]             out_act_reg;
    logic                   clipped_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_MUL_LO;
                end
            end
            B_MUL_LO: state_next = B_MUL_HI;
            B_MUL_HI: state_next = B_SUM;
            B_SUM:    state_next = B_BIAS;
            B_BIAS:   state_next = B_ABS;
            B_ABS:    state_next = B_ROUND;
            B_ROUND:  state_next = B_SAT;
            B_SAT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    assign bias_ext = {{(VW-BIAS_W){bias[BIAS_W-1]}}, bias};
    assign half     = (frac_shift == '0) ? '0 : (VW'(1) << (frac_shift - 1'b1));
    assign rounded  = (v_reg + half) >> frac_shift;

    // Saturate the rounded magnitude; the sign comes from vneg_reg.
    assign upper_nz = |v_reg[VW-1:8];
    always_comb
    begin
        if (!vneg_reg)
        begin
            sat_clip = upper_nz || v_reg[7];
            sat_act  = sat_clip ? INT8_MAX : v_reg[7:0];
        end
        else
        begin
            sat_clip = upper_nz || (v_reg[7:0] > INT8_MIN);
            sat_act  = sat_clip ? INT8_MIN : (8'd0 - v_reg[7:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                aneg_reg <= q_rdata[ACC_WIDTH-1];
                mag_reg  <= q_rdata[ACC_WIDTH-1] ? (~q_rdata + 1'b1) : q_rdata;
            end
            B_MUL_LO:
            begin
                plo_reg <= (LOW+MULT_W)'(mag_reg[LOW-1:0]) * (LOW+MULT_W)'(mult);
            end
            B_MUL_HI:
            begin
                phi_reg <= (HIW+MULT_W)'(mag_reg[ACC_WIDTH-1:LOW]) * (HIW+MULT_W)'(mult);
            end
            B_SUM:
            begin
                v_reg <= VW'(plo_reg) + (VW'(phi_reg) << LOW);
            end
            B_BIAS:
            begin
                v_reg <= aneg_reg ? (bias_ext - v_reg) : (bias_ext + v_reg);
            end
            B_ABS:
            begin
                if (v_reg[VW-1] && relu_en)
                begin
                    v_reg    <= '0;
                    vneg_reg <= 1'b0;
                end
                else
                begin
                    v_reg    <= v_reg[VW-1] ? (~v_reg + 1'b1) : v_reg;
                    vneg_reg <= v_reg[VW-1];
                end
            end
            B_ROUND:
            begin
                v_reg <= rounded;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_act_reg <= sat_act;
            clipped_reg <= sat_clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_act   = out_act_reg;
    assign clipped   = clipped_reg;

endmodule

// File: hdl/int8_dual_mac_requant_neuron.sv
// Top level of the int8 dual MAC neuron with fixed-point requantization.
//
// Input channel (in_valid/in_ready): each transfer carries two signed int8
// weight/activation pairs; both products add into a wrapping ACC_WIDTH-bit
// accumulator. The transfer with last_pair set closes the dot product: its
// sum goes into a two-entry queue and the accumulator clears.
// Output channel (out_valid/out_ready): one transfer per dot product with the
// requantized int8 activation and a saturation flag.
// Config port: cfg_we writes cfg_data into register cfg_idx (mult,
// frac_shift, bias, relu_en), write only while the block is idle.
// Flow: the front end accepts a transfer whenever a queue entry is free.
// The back end runs a sequence of steps per dot product (pop, two partial
// products of the magnitude halves with mult, sum, bias, sign/ReLU, round,
// saturate) and pops the next sum only after it has finished the last one;
// the front end stalls only when both queue entries wait.
// Reset: accumulator, queue and output valid clear; registers take their
// defaults (mult 1.0 in Q16, frac_shift 16, bias 0, ReLU on).
// Receiver stall: the result holds in the output register; the back end
// finishes the next sum and waits in its saturate step, the queue fills,
// then in_ready drops.
module int8_dual_mac_requant_neuron #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dmrn_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [dmrn_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [7:0]               weight_lo,
    input  logic signed [7:0]               act_lo,
    input  logic signed [7:0]               weight_hi,
    input  logic signed [7:0]               act_hi,
    input  logic                            last_pair,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [7:0]               out_act,
    output logic                            clipped
);
    import dmrn_pkg::*;

    logic [MULT_W-1:0]      mult_reg;
    logic [FS_W-1:0]        fs_reg;
    logic [BIAS_W-1:0]      bias_reg;
    logic                   relu_reg;

    q_stat_t                q_stat;
    logic                   q_push;
    logic                   q_pop;
    logic [ACC_WIDTH-1:0]   q_wdata;
    logic [ACC_WIDTH-1:0]   q_rdata;

    // Configuration registers: plain write, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
            fs_reg   <= FS_RESET;
            bias_reg <= '0;
            relu_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MULT:       mult_reg <= cfg_data[MULT_W-1:0];
                CFG_FRAC_SHIFT: fs_reg   <= cfg_data[FS_W-1:0];
                CFG_BIAS:       bias_reg <= cfg_data[BIAS_W-1:0];
                CFG_RELU_EN:    relu_reg <= cfg_data[0];
                default:        relu_reg <= relu_reg;
            endcase
        end
    end

    // Accumulate pairs; push the closed sum.
    dmrn_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .weight_lo (weight_lo),
        .act_lo    (act_lo),
        .weight_hi (weight_hi),
        .act_hi    (act_hi),
        .last_pair (last_pair),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // Decouple accumulation from requantization.
    dmrn_queue #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // Requantize, round, saturate and hold the result for the receiver.
    dmrn_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mult       (mult_reg),
        .frac_shift (fs_reg),
        .bias       (bias_reg),
        .relu_en    (relu_reg),
        .q_rdata    (q_rdata),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_act    (out_act),
        .clipped    (clipped)
    );

    // A closed sum is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // The back end pops only a queue that holds a sum.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // A pop with no push leaves the queue not full on the next cycle.
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> !q_stat.full)
        else $error("queue still full after pop");

endmodule
